// ===== sv/dof_pkg.sv =====
// Shared types and constants for the DHCP option finder.
// Used by dof_scan and dhcp_option_finder; depends on nothing else.
package dof_pkg;

  localparam int unsigned DOF_OPTIONS_LIMIT = 128;
  localparam int unsigned DOF_OFFSET_W      = 10;
  localparam logic [DOF_OFFSET_W-1:0] DOF_OFFSET_MAX = '1;
  localparam logic [7:0]  DOF_END_CODE      = 8'd255;
  localparam logic [7:0]  DOF_WANTED_RESET  = 8'd6;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_ABSENT     = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_LIMIT      = 3'd3,
    ST_AREA_ENDED = 3'd4
  } dof_status_t;

  typedef struct packed {
    logic        valid;
    dof_status_t status;
    logic [31:0] value;
  } dof_result_t;

endpackage

// ===== sv/dhcp_option_finder.sv =====
// Top level of the DHCP option finder: configuration register, byte walker
// and result register. Depends on dof_pkg and dof_scan.
//
// Usage: the bytes of a DHCP options area enter on the in_ stream, one byte
// per request, with in_tuser marking the first byte of an area and in_tlast
// the final one. The option code to look for is written on the cfg_ port
// while the block is idle; after reset it is 6. For each area at most one
// result leaves on the out_ stream: a status and, when found, the option
// value read little-endian. Bytes after a result are ignored until the
// next first byte.
// Throughput is one byte per cycle while no stalled result holds in_tready low.
// A result appears on out_tvalid in the cycle after the byte that produced it,
// set by the single result register after the walker logic.
// Reset clears the search as if a new area had just begun. When the
// receiver stalls with a result pending, in_tready drops and no byte is
// taken until that result is accepted; with no result pending, bytes keep
// flowing regardless of out_tready.
module dhcp_option_finder
  import dof_pkg::*;
#(
  parameter int unsigned OPTIONS_LIMIT = DOF_OPTIONS_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // [7:0] wanted_code
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] option_byte
  input  logic        in_tuser,      // [0] first_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // [2:0] status, [34:3] option_value, zero pad
);

  logic [7:0]  wanted_r;
  logic        out_valid_r;
  dof_status_t out_status_r;
  logic [31:0] out_value_r;
  logic        in_acc;
  dof_result_t result;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= DOF_WANTED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wanted_r <= cfg_data;
    end
  end

  dof_scan #(
    .OPTIONS_LIMIT(OPTIONS_LIMIT)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_acc),
    .option_byte (in_tdata),
    .first_byte  (in_tuser),
    .last_byte   (in_tlast),
    .wanted_code (wanted_r),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_acc && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && result.valid) begin
      out_status_r <= result.status;
      out_value_r  <= result.value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_value_r, out_status_r};

  // Only a found option carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status_r == ST_FOUND || out_value_r == 32'd0))
    else $error("nonzero value on a result other than found");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status_r == ST_FOUND || out_status_r == ST_ABSENT ||
                    out_status_r == ST_BAD_SIZE || out_status_r == ST_LIMIT ||
                    out_status_r == ST_AREA_ENDED))
    else $error("result status out of range");

  // An area that opens with the end marker reports absent at once.
  a_first_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser && in_tdata == DOF_END_CODE) |=>
      (out_tvalid && out_status_r == ST_ABSENT))
    else $error("end marker at area start gave no absent result");

  // A one-byte area always ends with a result.
  a_single_byte_area: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser && in_tlast) |=> out_tvalid)
    else $error("one-byte area gave no result");

endmodule

// ===== sv/dof_scan.sv =====
// Per-byte record walker of the DHCP option finder: holds the search state
// and computes the result of one byte. Depends on dof_pkg.
module dof_scan
  import dof_pkg::*;
#(
  parameter int unsigned OPTIONS_LIMIT = DOF_OPTIONS_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  option_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [7:0]  wanted_code,
  output dof_result_t result
);

  typedef enum logic [2:0] {
    PH_CODE       = 3'd0,
    PH_SIZE_OTHER = 3'd1,
    PH_SIZE_MATCH = 3'd2,
    PH_SKIP       = 3'd3,
    PH_VALUE      = 3'd4
  } phase_t;

  localparam logic [DOF_OFFSET_W-1:0] LimitOff = DOF_OFFSET_W'(OPTIONS_LIMIT);

  phase_t                  phase_r, phase_nxt, phase_c;
  logic [DOF_OFFSET_W-1:0] offset_r, offset_nxt, offset_c;
  logic [7:0]              left_r, left_nxt, left_c;
  logic [2:0]              size_r, size_nxt, size_c;
  logic [1:0]              idx_r, idx_nxt, idx_c;
  logic [31:0]             acc_r, acc_nxt, acc_c, acc_new;
  logic                    fin_r, fin_nxt, fin_c;
  logic [DOF_OFFSET_W:0]   offset_sum;
  logic                    have;
  dof_status_t             status;
  logic [31:0]             value;

  // A first byte restarts the search before the byte itself is walked.
  assign phase_c  = first_byte ? PH_CODE : phase_r;
  assign offset_c = first_byte ? '0 : offset_r;
  assign left_c   = first_byte ? '0 : left_r;
  assign size_c   = first_byte ? '0 : size_r;
  assign idx_c    = first_byte ? '0 : idx_r;
  assign acc_c    = first_byte ? '0 : acc_r;
  assign fin_c    = first_byte ? 1'b0 : fin_r;

  assign offset_sum = {1'b0, offset_c} + (DOF_OFFSET_W+1)'(option_byte)
                      + (DOF_OFFSET_W+1)'(2);
  assign acc_new    = acc_c | (32'(option_byte) << {idx_c, 3'b000});

  always_comb begin
    phase_nxt  = phase_c;
    offset_nxt = offset_c;
    left_nxt   = left_c;
    size_nxt   = size_c;
    idx_nxt    = idx_c;
    acc_nxt    = acc_c;
    fin_nxt    = fin_c;
    have       = 1'b0;
    status     = ST_FOUND;
    value      = '0;
    if (!fin_c) begin
      case (phase_c)
        PH_CODE: begin
          // The end marker is checked before the offset limit.
          if (option_byte == DOF_END_CODE) begin
            have   = 1'b1;
            status = ST_ABSENT;
          end else if (offset_c >= LimitOff) begin
            have   = 1'b1;
            status = ST_LIMIT;
          end else begin
            phase_nxt = (option_byte == wanted_code) ? PH_SIZE_MATCH : PH_SIZE_OTHER;
          end
        end
        PH_SIZE_OTHER: begin
          offset_nxt = offset_sum[DOF_OFFSET_W] ? DOF_OFFSET_MAX
                                                : offset_sum[DOF_OFFSET_W-1:0];
          left_nxt   = option_byte;
          phase_nxt  = (option_byte == 8'd0) ? PH_CODE : PH_SKIP;
        end
        PH_SIZE_MATCH: begin
          if (option_byte inside {8'd1, 8'd2, 8'd4}) begin
            size_nxt  = option_byte[2:0];
            acc_nxt   = '0;
            idx_nxt   = '0;
            phase_nxt = PH_VALUE;
          end else begin
            have   = 1'b1;
            status = ST_BAD_SIZE;
          end
        end
        PH_SKIP: begin
          left_nxt = left_c - 8'd1;
          if (left_c == 8'd1) begin
            phase_nxt = PH_CODE;
          end
        end
        PH_VALUE: begin
          acc_nxt = acc_new;
          if (({1'b0, idx_c} + 3'd1) >= size_c) begin
            have   = 1'b1;
            status = ST_FOUND;
            value  = acc_new;
          end else begin
            idx_nxt = idx_c + 2'd1;
          end
        end
        default: begin
          phase_nxt = PH_CODE;
        end
      endcase
      if (!have && last_byte) begin
        have   = 1'b1;
        status = ST_AREA_ENDED;
      end
      if (have) begin
        fin_nxt = 1'b1;
      end
    end
  end

  assign result.valid  = have;
  assign result.status = status;
  assign result.value  = value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CODE;
      offset_r <= '0;
      left_r   <= '0;
      size_r   <= '0;
      idx_r    <= '0;
      fin_r    <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      left_r   <= left_nxt;
      size_r   <= size_nxt;
      idx_r    <= idx_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for dhcp_option_finder: streams option areas in, predicts
// each lookup result and compares it with the out_ stream. Depends on dof_pkg and dhcp_option_finder.
module tb_top;
  import dof_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SEGMENT_BYTES = 75;

  typedef enum logic [2:0] {
    WALK_CODE, WALK_SIZE_OTHER, WALK_SIZE_MATCH, WALK_SKIP, WALK_VALUE
  } walk_phase_t;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    bit         drain_first;
  } option_req_t;

  typedef struct {
    dof_status_t status;
    logic [31:0] value;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  option_req_t    byte_backlog[$];
  lookup_result_t awaited_lookups[$];

  // Predicted state of the byte walker.
  logic [7:0]  search_code = DOF_WANTED_RESET;
  walk_phase_t walk_phase = WALK_CODE;
  int unsigned rec_offset = 0;
  logic [7:0]  skip_left = '0;
  logic [7:0]  match_size = '0;
  logic [31:0] value_acc = '0;
  logic [1:0]  value_idx = '0;
  bit          area_done = 1'b0;

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 60;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned areas_queued = 0;
  int unsigned status_tally[5] = '{default: 0};
  int unsigned quiet_cycles = 0;

  dhcp_option_finder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic walk_option_byte(input logic [7:0] b, input logic first, input logic last);
    bit             have;
    lookup_result_t res;
    int unsigned    next_offset;
    have = 1'b0;
    res.status = ST_FOUND;
    res.value = '0;
    if (first) begin
      walk_phase = WALK_CODE;
      rec_offset = 0;
      skip_left = '0;
      match_size = '0;
      value_acc = '0;
      value_idx = '0;
      area_done = 1'b0;
    end
    if (!area_done) begin
      case (walk_phase)
        WALK_CODE: begin
          // The end marker wins over the offset limit.
          if (b == DOF_END_CODE) begin
            have = 1'b1;
            res.status = ST_ABSENT;
          end else if (rec_offset >= DOF_OPTIONS_LIMIT) begin
            have = 1'b1;
            res.status = ST_LIMIT;
          end else begin
            walk_phase = (b == search_code) ? WALK_SIZE_MATCH : WALK_SIZE_OTHER;
          end
        end
        WALK_SIZE_OTHER: begin
          next_offset = rec_offset + b + 2;
          rec_offset = (next_offset > DOF_OFFSET_MAX) ? DOF_OFFSET_MAX : next_offset;
          skip_left = b;
          walk_phase = (b == 8'd0) ? WALK_CODE : WALK_SKIP;
        end
        WALK_SIZE_MATCH: begin
          if (b == 8'd1 || b == 8'd2 || b == 8'd4) begin
            match_size = b;
            value_acc = '0;
            value_idx = '0;
            walk_phase = WALK_VALUE;
          end else begin
            have = 1'b1;
            res.status = ST_BAD_SIZE;
          end
        end
        WALK_SKIP: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0) walk_phase = WALK_CODE;
        end
        default: begin
          value_acc = value_acc | (32'(b) << (8 * value_idx));
          if (32'(value_idx) + 1 >= 32'(match_size)) begin
            have = 1'b1;
            res.status = ST_FOUND;
            res.value = value_acc;
          end else begin
            value_idx = value_idx + 2'd1;
          end
        end
      endcase
      if (!have && last) begin
        have = 1'b1;
        res.status = ST_AREA_ENDED;
      end
      if (have) begin
        area_done = 1'b1;
        awaited_lookups.push_back(res);
      end
    end
  endtask

  // Driver: a new request is offered only when the current one is taken.
  always @(posedge clk) begin : drive_p
    option_req_t cur;
    bit          offer;
    if (rst_n && (!in_tvalid || in_tready)) begin
      offer = byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct;
      // A held request waits until nothing is in flight and no result is pending.
      if (offer && byte_backlog[0].drain_first &&
          (awaited_lookups.size() != 0 || out_tvalid || in_tvalid)) offer = 1'b0;
      if (offer) begin
        cur = byte_backlog.pop_front();
        in_tdata <= cur.data;
        in_tuser <= cur.first;
        in_tlast <= cur.last;
      end
      in_tvalid <= offer;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_p
    lookup_result_t want;
    logic [2:0]     got_status;
    logic [31:0]    got_value;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) search_code = cfg_data;
      if (in_tvalid && in_tready) begin
        bytes_sent++;
        walk_option_byte(in_tdata, in_tuser, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[2:0];
        got_value = out_tdata[34:3];
        if (awaited_lookups.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status %0d value %h", $time, got_status,
                   got_value);
        end else begin
          want = awaited_lookups.pop_front();
          if (got_status < 3'd5) status_tally[got_status]++;
          if (got_status != want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
          end
          if (got_value != want.value) begin
            mismatches++;
            $display("%0t: value expected %h actual %h", $time, want.value, got_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("dhcp_option_finder verification failed");
        $finish;
      end
    end
  end

  task automatic queue_area(input byte_q_t body, input bit with_first, input bit with_last,
                            input bit hold);
    option_req_t req;
    for (int i = 0; i < body.size(); i++) begin
      req.data = body[i];
      req.first = with_first && i == 0;
      req.last = with_last && i == body.size() - 1;
      req.drain_first = hold && i == 0;
      byte_backlog.push_back(req);
    end
    areas_queued++;
  endtask

  function automatic logic [7:0] other_code(input logic [7:0] sought);
    logic [7:0] c;
    c = 8'($urandom_range(0, 254));
    if (c == sought) c = (c == 8'd254) ? 8'd0 : c + 8'd1;
    return c;
  endfunction

  // Mostly well-formed areas with random records, plus noise and cut-off areas.
  task automatic add_random_area(input logic [7:0] sought);
    byte_q_t     body;
    option_req_t req;
    int unsigned nrec, len, pick, offset;
    bit          limit_run;
    body = {};
    offset = 0;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
    end else begin
      nrec = $urandom_range(0, 4);
      limit_run = $urandom_range(99) < 8;
      while (nrec != 0 || (limit_run && offset < DOF_OPTIONS_LIMIT)) begin
        if (nrec != 0) nrec--;
        if (limit_run) len = $urandom_range(20, 120);
        else if ($urandom_range(9) == 0) len = $urandom_range(0, 255);
        else len = $urandom_range(0, 5);
        body.push_back(other_code(sought));
        body.push_back(8'(len));
        repeat (len) body.push_back(8'($urandom));
        offset += len + 2;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        body.push_back(sought);
        case ($urandom_range(9))
          0, 1:    len = $urandom_range(0, 255);
          2, 3, 4: len = 4;
          5, 6:    len = 2;
          default: len = 1;
        endcase
        body.push_back(8'(len));
        if (len == 1 || len == 2 || len == 4) begin
          pick = $urandom_range(7);
          repeat (len)
            body.push_back(pick == 0 ? 8'hFF : (pick == 1 ? 8'h00 : 8'($urandom)));
        end
      end else if (pick < 75) begin
        body.push_back(DOF_END_CODE);
      end else if (pick >= 90) begin
        body.push_back(sought);
      end
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
      if (body.size() > 1 && $urandom_range(9) == 0)
        body = body[0:$urandom_range(0, body.size() - 1)];
    end
    if (body.size() == 0) body.push_back(8'($urandom));
    for (int i = 0; i < body.size(); i++) begin
      req.data = body[i];
      req.first = (i == 0) && ($urandom_range(99) < 95);
      req.last = (i == body.size() - 1) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 2);
      req.drain_first = (i == 0) && ($urandom_range(99) < 3);
      byte_backlog.push_back(req);
    end
    areas_queued++;
  endtask

  task automatic wait_quiet();
    while (byte_backlog.size() != 0 || in_tvalid || awaited_lookups.size() != 0 || out_tvalid)
      @(posedge clk);
    // The closing wait lets a byte with no result settle.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_search_code(input logic [7:0] code);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus_p
    byte_q_t     body;
    logic [7:0]  seg_code[6];
    int unsigned start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed areas with the reset search code of 6.
    queue_area('{8'd6, 8'd1, 8'hAB}, 1'b0, 1'b0, 1'b0);
    queue_area('{DOF_END_CODE}, 1'b1, 1'b0, 1'b1);
    queue_area('{8'd6, 8'd4, 8'h00, 8'hFF, 8'h01, 8'h80}, 1'b1, 1'b1, 1'b0);
    queue_area('{8'd3, 8'd0, 8'd6, 8'd2, 8'h34, 8'h12, 8'h55}, 1'b1, 1'b1, 1'b0);
    queue_area('{8'd6, 8'd3}, 1'b1, 1'b0, 1'b0);
    queue_area('{8'd6, 8'd0}, 1'b1, 1'b0, 1'b0);
    queue_area('{8'd6, 8'd255}, 1'b1, 1'b0, 1'b0);
    queue_area('{8'd1, 8'd2, 8'hAA, 8'hBB}, 1'b1, 1'b1, 1'b0);
    queue_area('{8'd6, 8'd4, 8'h11}, 1'b1, 1'b0, 1'b0);
    queue_area('{DOF_END_CODE}, 1'b1, 1'b0, 1'b0);
    queue_area('{8'd6, 8'd2, 8'hFF, 8'hFF}, 1'b1, 1'b1, 1'b0);
    queue_area('{8'd5}, 1'b1, 1'b1, 1'b0);
    // End marker exactly at the offset limit still reads as not found.
    body = '{8'd7, 8'd126};
    repeat (126) body.push_back(8'($urandom));
    body.push_back(DOF_END_CODE);
    queue_area(body, 1'b1, 1'b0, 1'b0);
    // Records of 255 bytes each; the second code byte lies past the offset limit.
    body = {};
    repeat (3) begin
      body.push_back(8'd7);
      body.push_back(8'd255);
      repeat (255) body.push_back(8'($urandom));
    end
    // A fourth record, cut after its size byte, closes the area.
    body.push_back(8'd7);
    body.push_back(8'd255);
    queue_area(body, 1'b1, 1'b1, 1'b0);
    wait_quiet();

    seg_code = '{8'd0, 8'($urandom_range(1, 254)), DOF_END_CODE,
                 8'($urandom_range(1, 254)), 8'd254, DOF_WANTED_RESET};
    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 60;
      end else if (seg < 4) begin
        send_idle_pct = 60;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_search_code(seg_code[seg]);
      start = byte_backlog.size();
      while (byte_backlog.size() - start < SEGMENT_BYTES) add_random_area(seg_code[seg]);
      wait_quiet();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d option bytes in %0d areas over six search codes and three idle mixes.",
             bytes_sent, areas_queued);
    $display("Results: found %0d, absent %0d, bad size %0d, limit %0d, area ended %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatches == 0)
      $display("dhcp_option_finder verification clean");
    else
      $display("dhcp_option_finder verification failed");
    $finish;
  end

endmodule
